/* rtl/drive_deadband_slew_limiter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the drive deadband slew limiter
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DRIVE_DEADBAND_SLEW_LIMITER_ASSERT_SVH
`define DRIVE_DEADBAND_SLEW_LIMITER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked at every rising clock edge out of reset
`define DSL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
// next-cycle implication
`define DSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`else
`define DSL_ASSERT_IMPL(lbl, ante, cons)
`define DSL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/dsl_pkg.sv */
// ----------------------------------------------------------------------------
// dsl_pkg
// Shared widths, register indexes, reset values and helper types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsl_pkg;

  // stick magnitude and full scale
  localparam int MAG_W = 7;
  localparam logic [MAG_W-1:0] FULL_SCALE = 7'd127;

  // output power, signed
  localparam int POWER_W = 8;

  // configuration field widths
  localparam int GAIN_W = 10;
  localparam int STEP_W = 7;
  localparam int DEG_W  = 2;

  // gain * |x|^3 fits in 31 bits; Q2.8 fraction dropped before the divide
  localparam int NUM_W   = 31;
  localparam int FRAC_W  = 8;
  localparam int SNUM_W  = NUM_W - FRAC_W;
  localparam int SDIV_W  = 14;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MS_PER_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_DEGREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_GAIN   = 3'd4;

  // register reset values
  localparam logic                 RST_RAMP_ENABLE  = 1'b0;
  localparam logic [STEP_W-1:0]    RST_MS_PER_STEP  = 7'd5;
  localparam logic [MAG_W-1:0]     RST_DEADBAND     = 7'd10;
  localparam logic [DEG_W-1:0]     RST_CURVE_DEGREE = 2'd1;
  localparam logic [GAIN_W-1:0]    RST_POWER_GAIN   = 10'd256;

  // curve divisors 127^(d-1)
  localparam logic [SDIV_W-1:0] DIV_LINEAR = 14'd1;
  localparam logic [SDIV_W-1:0] DIV_SQUARE = 14'd127;
  localparam logic [SDIV_W-1:0] DIV_CUBE   = 14'd16129;

  localparam logic [DEG_W-1:0] DEG_TWO   = 2'd2;
  localparam logic [DEG_W-1:0] DEG_THREE = 2'd3;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

  function automatic logic [SDIV_W-1:0] shape_divisor(input logic [DEG_W-1:0] deg);
    logic [SDIV_W-1:0] res;
    case (deg)
      DEG_TWO:   res = DIV_SQUARE;
      DEG_THREE: res = DIV_CUBE;
      default:   res = DIV_LINEAR;
    endcase
    return res;
  endfunction

endpackage

/* rtl/drive_deadband_slew_limiter.sv */
// ----------------------------------------------------------------------------
// drive_deadband_slew_limiter
// Shapes a joystick sample by gain and curve, applies a deadband and limits
// the per-side rate of power change against elapsed milliseconds.
// ----------------------------------------------------------------------------
//
//   port group   direction  handshake               payload
//   in_*         input      in_valid / in_ready     side, stick value, time
//   out_*        output     out_valid / out_ready   side, power, limited flag
//   cfg_*        input      cfg_we (no wait)        register index, data
//
// An item goes through the serial multiplier (once per curve degree d) and
// then the shape divider, while the time divider runs in parallel from the
// transfer in; in_ready returns when the ramp step completes.
// Reset is synchronous; stored power and step times clear to zero at once.
// A result waiting on out_ready does not block the next transfer in; the
// block stalls only when a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drive_deadband_slew_limiter #(
  parameter int NUM_SIDES = 2,
  parameter int TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_side,
  input  logic signed [dsl_pkg::POWER_W-1:0] in_stick_value,
  input  logic [TIME_BITS-1:0]             in_now_ms,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_side,
  output logic signed [dsl_pkg::POWER_W-1:0] out_motor_power,
  output logic                             out_rate_limited,
  // configuration port
  input  logic                             cfg_we,
  input  logic [dsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dsl_pkg::*;

`include "drive_deadband_slew_limiter_assert.svh"

  localparam int IW = (NUM_SIDES > 1) ? $clog2(NUM_SIDES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SIDES - 1);
  localparam int P9 = POWER_W + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_RAMP = 4'b1000
  } state_t;

  // configuration registers
  logic               ramp_enable_r;
  logic [STEP_W-1:0]  ms_per_step_r;
  logic [MAG_W-1:0]   deadband_r;
  logic [DEG_W-1:0]   curve_degree_r;
  logic [GAIN_W-1:0]  power_gain_r;

  // control and item registers
  state_t               state_r;
  logic                 side_r;
  logic                 neg_r;
  logic [IW-1:0]        idx_r;
  logic [TIME_BITS-1:0] now_r;
  logic [POWER_W-1:0]   target_r;
  logic                 out_valid_r;
  logic                 out_side_r;
  logic [POWER_W-1:0]   out_power_r;
  logic                 out_limited_r;

  // per-side state
  logic [POWER_W-1:0]   side_power_r [NUM_SIDES];
  logic [TIME_BITS-1:0] last_time_r  [NUM_SIDES];

  // unit handshakes and results
  ser_stat_t            mul_stat;
  ser_stat_t            sdiv_stat;
  ser_stat_t            tdiv_stat;
  logic [NUM_W-1:0]     mul_product;
  logic [SNUM_W-1:0]    sdiv_quo;
  logic [SDIV_W-1:0]    sdiv_rem;
  logic [TIME_BITS-1:0] tdiv_quo;
  logic [STEP_W-1:0]    tdiv_rem;

  // decode
  logic [DEG_W-1:0]     deg_eff;
  logic [STEP_W-1:0]    step_eff;
  logic                 in_fire;
  logic                 neg_c;
  logic [POWER_W-1:0]   mag8_c;
  logic [MAG_W-1:0]     mag_c;
  logic [IW-1:0]        idx_c;
  logic [TIME_BITS-1:0] elapsed_c;
  logic                 sdiv_start;

  // target shaping
  logic [MAG_W-1:0]     m_sat;
  logic [MAG_W-1:0]     m_db;
  logic [POWER_W-1:0]   tgt_c;

  // ramp step
  logic [POWER_W-1:0]   cur_c;
  logic [P9-1:0]        diff9;
  logic [P9-1:0]        absdiff;
  logic                 past_step;
  logic                 close_c;
  logic                 up_c;
  logic [P9-1:0]        stepped9;
  logic [POWER_W-1:0]   power_c;
  logic                 upd_time;
  logic [TIME_BITS-1:0] new_time;
  logic                 ramp_fire;

  // treat zero degree and zero step as one
  assign deg_eff  = (curve_degree_r == '0) ? DEG_W'(1) : curve_degree_r;
  assign step_eff = (ms_per_step_r == '0) ? STEP_W'(1) : ms_per_step_r;

  // input decode: magnitude clipped to full scale, side folded into range
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign neg_c     = in_stick_value[POWER_W-1];
  assign mag8_c    = neg_c ? (POWER_W'(0) - in_stick_value) : in_stick_value;
  assign mag_c     = mag8_c[POWER_W-1] ? FULL_SCALE : mag8_c[MAG_W-1:0];
  assign idx_c     = (NUM_SIDES > 1) ? IW'(in_side) : LAST_IDX;
  assign elapsed_c = in_now_ms - last_time_r[idx_c];

  assign sdiv_start = (state_r == S_MUL) && mul_stat.done;

  // gain * |x|^d
  dsl_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_fire),
    .gain    (power_gain_r),
    .mag     (mag_c),
    .passes  (deg_eff),
    .stat    (mul_stat),
    .product (mul_product)
  );

  // (gain * |x|^d / 256) / 127^(d-1)
  dsl_serial_div #(
    .DW (SNUM_W),
    .VW (SDIV_W)
  ) u_shape_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (sdiv_start),
    .dividend  (mul_product[NUM_W-1:FRAC_W]),
    .divisor   (shape_divisor(deg_eff)),
    .stat      (sdiv_stat),
    .quotient  (sdiv_quo),
    .remainder (sdiv_rem)
  );

  // elapsed / ms_per_step, started right at the transfer in
  dsl_serial_div #(
    .DW (TIME_BITS),
    .VW (STEP_W)
  ) u_time_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire),
    .dividend  (elapsed_c),
    .divisor   (step_eff),
    .stat      (tdiv_stat),
    .quotient  (tdiv_quo),
    .remainder (tdiv_rem)
  );

  // saturate, apply deadband, restore sign
  assign m_sat = (|sdiv_quo[SNUM_W-1:MAG_W]) ? FULL_SCALE : sdiv_quo[MAG_W-1:0];
  assign m_db  = (m_sat < deadband_r) ? '0 : m_sat;
  assign tgt_c = neg_r ? (POWER_W'(0) - {1'b0, m_db}) : {1'b0, m_db};

  // ramp toward the target by at most elapsed / ms_per_step
  assign cur_c     = side_power_r[idx_r];
  assign diff9     = {cur_c[POWER_W-1], cur_c} - {target_r[POWER_W-1], target_r};
  assign absdiff   = diff9[P9-1] ? (P9'(0) - diff9) : diff9;
  assign past_step = (|tdiv_quo[TIME_BITS-1:1]) || (tdiv_quo[0] && (tdiv_rem != '0));
  assign close_c   = (|tdiv_quo[TIME_BITS-1:P9]) || (tdiv_quo[P9-1:0] > absdiff);
  assign up_c      = $signed(target_r) > $signed(cur_c);
  assign stepped9  = up_c ? ({cur_c[POWER_W-1], cur_c} + tdiv_quo[P9-1:0])
                          : ({cur_c[POWER_W-1], cur_c} - tdiv_quo[P9-1:0]);

  always_comb begin
    power_c  = target_r;
    upd_time = 1'b0;
    new_time = now_r;
    if (ramp_enable_r) begin
      if (!past_step) begin
        power_c = cur_c;
      end else if (close_c) begin
        upd_time = 1'b1;
      end else begin
        power_c  = stepped9[POWER_W-1:0];
        upd_time = 1'b1;
        new_time = now_r - TIME_BITS'(tdiv_rem);
      end
    end
  end

  assign ramp_fire = (state_r == S_RAMP) && !tdiv_stat.busy && (!out_valid_r || out_ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_enable_r  <= RST_RAMP_ENABLE;
      ms_per_step_r  <= RST_MS_PER_STEP;
      deadband_r     <= RST_DEADBAND;
      curve_degree_r <= RST_CURVE_DEGREE;
      power_gain_r   <= RST_POWER_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RAMP_ENABLE:  ramp_enable_r  <= cfg_data[0];
        REG_MS_PER_STEP:  ms_per_step_r  <= cfg_data[STEP_W-1:0];
        REG_DEADBAND:     deadband_r     <= cfg_data[MAG_W-1:0];
        REG_CURVE_DEGREE: curve_degree_r <= cfg_data[DEG_W-1:0];
        REG_POWER_GAIN:   power_gain_r   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_fire) state_r <= S_MUL;
        S_MUL:  if (mul_stat.done) state_r <= S_DIV;
        S_DIV:  if (sdiv_stat.done) state_r <= S_RAMP;
        S_RAMP: if (ramp_fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // capture item fields and the shaped target
  always_ff @(posedge clk) begin
    if (in_fire) begin
      side_r <= in_side;
      neg_r  <= neg_c;
      idx_r  <= idx_c;
      now_r  <= in_now_ms;
    end
    if (state_r == S_DIV && sdiv_stat.done) begin
      target_r <= tgt_c;
    end
  end

  // per-side power and step time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SIDES; i++) begin
        side_power_r[i] <= '0;
        last_time_r[i]  <= '0;
      end
    end else if (ramp_fire) begin
      side_power_r[idx_r] <= power_c;
      if (upd_time) begin
        last_time_r[idx_r] <= new_time;
      end
    end
  end

  // output register: load on ramp completion, drop on transfer out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ramp_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ramp_fire) begin
      out_side_r    <= side_r;
      out_power_r   <= power_c;
      out_limited_r <= ramp_enable_r && (power_c != target_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_side         = out_side_r;
  assign out_motor_power  = out_power_r;
  assign out_rate_limited = out_limited_r;

  // checks
  `DSL_ASSERT_NEXT(a_tdiv_start, in_valid && in_ready, tdiv_stat.busy)
  `DSL_ASSERT_IMPL(a_units_idle, in_ready, !mul_stat.busy && !sdiv_stat.busy && !tdiv_stat.busy)
  `DSL_ASSERT_IMPL(a_mul_done, mul_stat.done, state_r == S_MUL)
  `DSL_ASSERT_IMPL(a_no_limit, out_valid_r && !ramp_enable_r, !out_limited_r)

endmodule

/* rtl/dsl_serial_mul.sv */
// ----------------------------------------------------------------------------
// dsl_serial_mul
// Shift-add multiplier: gain * a^passes, one multiplier bit of a per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsl_serial_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dsl_pkg::GAIN_W-1:0]   gain,
  input  logic [dsl_pkg::MAG_W-1:0]    mag,
  input  logic [dsl_pkg::DEG_W-1:0]    passes,
  output dsl_pkg::ser_stat_t           stat,
  output logic [dsl_pkg::NUM_W-1:0]    product
);
  import dsl_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(MAG_W - 1);
  localparam logic [DEG_W-1:0] ONE_PASS = DEG_W'(1);

  logic [NUM_W-1:0] mcand_r;
  logic [NUM_W-1:0] acc_r;
  logic [MAG_W-1:0] mplier_r;
  logic [MAG_W-1:0] mag_r;
  logic [CNT_W-1:0] bit_cnt_r;
  logic [DEG_W-1:0] pass_r;
  logic             busy_r;
  logic             done_r;
  logic [NUM_W-1:0] sum_nxt;

  // add the multiplicand when the current multiplier bit is set
  assign sum_nxt = acc_r + (mplier_r[0] ? mcand_r : '0);

  // control: busy and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_cnt_r == LAST_BIT && pass_r == ONE_PASS) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath: shift multiplicand left and multiplier right on each bit but the last of a pass
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r   <= NUM_W'(gain);
      acc_r     <= '0;
      mplier_r  <= mag;
      mag_r     <= mag;
      bit_cnt_r <= '0;
      pass_r    <= passes;
    end else if (busy_r) begin
      if (bit_cnt_r == LAST_BIT) begin
        if (pass_r == ONE_PASS) begin
          acc_r <= sum_nxt;
        end else begin
          // next pass multiplies the partial product by the magnitude again
          mcand_r   <= sum_nxt;
          acc_r     <= '0;
          mplier_r  <= mag_r;
          bit_cnt_r <= '0;
          pass_r    <= pass_r - ONE_PASS;
        end
      end else begin
        acc_r     <= sum_nxt;
        mcand_r   <= mcand_r << 1;
        mplier_r  <= mplier_r >> 1;
        bit_cnt_r <= bit_cnt_r + CNT_W'(1);
      end
    end
  end

  assign stat    = '{busy: busy_r, done: done_r};
  assign product = acc_r;

endmodule

/* rtl/dsl_serial_div.sv */
// ----------------------------------------------------------------------------
// dsl_serial_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsl_serial_div #(
  parameter int DW = 32,
  parameter int VW = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DW-1:0]      dividend,
  input  logic [VW-1:0]      divisor,
  output dsl_pkg::ser_stat_t stat,
  output logic [DW-1:0]      quotient,
  output logic [VW-1:0]      remainder
);
  import dsl_pkg::*;

  localparam int CW = $clog2(DW + 1);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  // bring down the next dividend bit and try the subtract
  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = trial >= {1'b0, div_r};

  // control: busy and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_ONE;
        if (cnt_r == CNT_ONE) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: shift quotient bits in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[VW-1:0] : trial[VW-1:0];
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

  assign stat      = '{busy: busy_r, done: done_r};
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
